@@ hw/rtl/nrbp_pkg.sv @@
// Package for the nearest ray box picker.
// Holds the table capacity, field widths and operation codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package nrbp_pkg;

  localparam int CAPACITY    = 16;
  localparam int CNT_W       = $clog2(CAPACITY + 1);
  localparam int IDX_W       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int SLOT_W      = 4;
  localparam int COORD_W     = 32;
  localparam int CFG_W       = 31;
  localparam int REACH_W     = 31;
  localparam int IN_TDATA_W  = 232;
  localparam int OUT_TDATA_W = 8;
  localparam int ENTRY_W     = 3 * COORD_W;
  localparam int DIV_W       = 50;
  localparam int DEN_W       = 32;
  localparam int BND_W       = 35;
  localparam int T_W         = DIV_W + 1;
  localparam int U_W         = 18;
  localparam int DCNT_W      = $clog2(DIV_W);

  typedef enum logic [1:0] {
    OP_SPAWN  = 2'd0,
    OP_REMOVE = 2'd1,
    OP_PICK   = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    CFG_BOX_WIDTH  = 2'd0,
    CFG_BOX_LENGTH = 2'd1,
    CFG_BOX_HEIGHT = 2'd2
  } cfg_idx_t;

endpackage
`default_nettype wire

@@ hw/rtl/nearest_ray_box_picker.sv @@
// Nearest ray box picker: an age-ordered anchor table with spawn, remove and pick; uses nrbp_pkg.
// Spawn appends an entry; when the table is full it first evicts its oldest entry.
// Remove shifts the entries behind the removed slot down one place; an unused opcode does nothing.
// Pick computes the square root and three 50-step divisions (only the square root for a zero
// direction), then runs the slab test on each stored box; one request at a time.
// Synchronous active-low reset empties the table and loads the box size defaults.
`timescale 1ns / 1ps
`default_nettype none
module nearest_ray_box_picker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // point_x, point_y, point_z, ray_dx, ray_dy, ray_dz, reach, slot_index, zero pad
  input  logic [nrbp_pkg::IN_TDATA_W-1:0]  in_tdata,
  // opcode
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // slot, evicted, hit, zero pad
  output logic [nrbp_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [nrbp_pkg::CFG_W-1:0] cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE, S_SHIFT_CHK, S_SHIFT_WR, S_SPAWN_WR, S_SQ, S_SQRT, S_UNIT,
    S_DIV, S_DIV_END, S_BOX_RD, S_BOX_LD, S_SLAB, S_DONE
  } state_t;

  localparam int CW = nrbp_pkg::COORD_W;

  state_t state_r;
  logic [1:0] op_r;
  logic signed [CW-1:0] px_r, py_r, pz_r, dx_r, dy_r, dz_r;
  logic [nrbp_pkg::REACH_W-1:0] reach_r;
  logic [nrbp_pkg::CFG_W-1:0] box_w_r, box_l_r, box_h_r;
  logic [nrbp_pkg::CNT_W-1:0] count_r, ptr_r;
  logic evict_r;

  logic [nrbp_pkg::ENTRY_W-1:0] mem_r [nrbp_pkg::CAPACITY];
  logic [nrbp_pkg::ENTRY_W-1:0] rd_data_r;
  logic [nrbp_pkg::IDX_W-1:0] rd_addr, mem_wa;
  logic [nrbp_pkg::ENTRY_W-1:0] mem_wd;
  logic mem_we;
  logic [nrbp_pkg::CNT_W:0] ptr_inc;

  logic [1:0] sq_cnt_r;
  logic [63:0] prod_r, acc_r, sres_r, sbit_r, ssum;
  logic [CW-1:0] sq_op;
  logic [nrbp_pkg::DEN_W-1:0] len_r;

  logic signed [nrbp_pkg::U_W-1:0] ux_r, uy_r, uz_r;
  logic [1:0] axis_r;
  logic bsel_r, unit_ph_r;
  logic signed [CW-1:0] ax_r, ay_r, az_r;

  logic [nrbp_pkg::DIV_W-1:0] div_num_r;
  logic [nrbp_pkg::DEN_W-1:0] div_den_r, div_rem_r;
  logic div_neg_r;
  logic [nrbp_pkg::DCNT_W-1:0] div_cnt_r;
  logic [nrbp_pkg::DEN_W:0] rem_sh, rem_sub;
  logic rem_ge;

  logic signed [nrbp_pkg::T_W-1:0] t1_r, tmin_r, tmax_r, best_t_r;
  logic signed [nrbp_pkg::T_W-1:0] q_ext, qs, t_lo, t_hi, new_tmin, new_tmax;
  logic [nrbp_pkg::IDX_W-1:0] best_r;
  logic found_r;

  logic [3:0] res_slot_r, out_slot_r;
  logic res_ev_r, res_hit_r, out_ev_r, out_hit_r, out_valid_r;

  logic signed [CW-1:0] d_axis;
  logic signed [nrbp_pkg::BND_W-1:0] o35, lo35, hi35, bnd, diff, diff_neg;
  logic signed [nrbp_pkg::BND_W-1:0] hw35, hl35, hh35;
  logic [33:0] mag;
  logic signed [nrbp_pkg::U_W-1:0] u_sel, u_neg;
  logic [nrbp_pkg::U_W-2:0] u_abs;
  logic outside, better_div, better_zero;

  function automatic logic [31:0] abs32(input logic signed [31:0] v);
    logic signed [31:0] n;
    n = -v;
    return v[31] ? n : v;
  endfunction

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_hit_r, out_ev_r, out_slot_r};

  // Table memory.
  assign ptr_inc = {1'b0, ptr_r} + 1'b1;
  assign rd_addr = (state_r == S_SHIFT_CHK) ? ptr_inc[nrbp_pkg::IDX_W-1:0]
                                            : ptr_r[nrbp_pkg::IDX_W-1:0];
  assign mem_we  = (state_r == S_SHIFT_WR) || (state_r == S_SPAWN_WR);
  assign mem_wa  = (state_r == S_SPAWN_WR) ? count_r[nrbp_pkg::IDX_W-1:0]
                                           : ptr_r[nrbp_pkg::IDX_W-1:0];
  assign mem_wd  = (state_r == S_SPAWN_WR) ? {pz_r, py_r, px_r} : rd_data_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_r[mem_wa] <= mem_wd;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  // Datapath selection.
  always_comb begin
    case (sq_cnt_r)
      2'd0:    sq_op = abs32(dx_r);
      2'd1:    sq_op = abs32(dy_r);
      default: sq_op = abs32(dz_r);
    endcase
    ssum = sres_r + sbit_r;

    hw35 = $signed({5'b0, box_w_r[nrbp_pkg::CFG_W-1:1]});
    hl35 = $signed({5'b0, box_l_r[nrbp_pkg::CFG_W-1:1]});
    hh35 = $signed({4'b0, box_h_r});
    case (axis_r)
      2'd0: begin
        d_axis = dx_r; u_sel = ux_r; o35 = 35'(px_r);
        lo35 = 35'(ax_r) - hw35; hi35 = 35'(ax_r) + hw35;
      end
      2'd1: begin
        d_axis = dy_r; u_sel = uy_r; o35 = 35'(py_r);
        lo35 = 35'(ay_r); hi35 = 35'(ay_r) + hh35;
      end
      default: begin
        d_axis = dz_r; u_sel = uz_r; o35 = 35'(pz_r);
        lo35 = 35'(az_r) - hl35; hi35 = 35'(az_r) + hl35;
      end
    endcase
    outside  = (o35 < lo35) || (o35 > hi35);
    bnd      = bsel_r ? hi35 : lo35;
    diff     = bnd - o35;
    diff_neg = -diff;
    mag      = diff[nrbp_pkg::BND_W-1] ? diff_neg[33:0] : diff[33:0];
    u_neg    = -u_sel;
    u_abs    = u_sel[nrbp_pkg::U_W-1] ? u_neg[nrbp_pkg::U_W-2:0]
                                      : u_sel[nrbp_pkg::U_W-2:0];

    rem_sh  = {div_rem_r, div_num_r[nrbp_pkg::DIV_W-1]};
    rem_sub = rem_sh - {1'b0, div_den_r};
    rem_ge  = (rem_sh >= {1'b0, div_den_r});

    q_ext    = $signed({1'b0, div_num_r});
    qs       = div_neg_r ? -q_ext : q_ext;
    t_lo     = (t1_r < qs) ? t1_r : qs;
    t_hi     = (t1_r < qs) ? qs : t1_r;
    new_tmin = (t_lo > tmin_r) ? t_lo : tmin_r;
    new_tmax = (t_hi < tmax_r) ? t_hi : tmax_r;
    better_div  = !found_r || (new_tmin < best_t_r);
    better_zero = !found_r || (tmin_r < best_t_r);
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      box_w_r     <= 31'd65536;
      box_l_r     <= 31'd65536;
      box_h_r     <= 31'd32768;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          nrbp_pkg::CFG_BOX_WIDTH:  box_w_r <= cfg_data;
          nrbp_pkg::CFG_BOX_LENGTH: box_l_r <= cfg_data;
          nrbp_pkg::CFG_BOX_HEIGHT: box_h_r <= cfg_data;
          default: ;
        endcase
      end
      if (out_valid_r && out_tready && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            op_r    <= in_tuser;
            px_r    <= in_tdata[31:0];
            py_r    <= in_tdata[63:32];
            pz_r    <= in_tdata[95:64];
            dx_r    <= in_tdata[127:96];
            dy_r    <= in_tdata[159:128];
            dz_r    <= in_tdata[191:160];
            reach_r <= in_tdata[222:192];
            sq_cnt_r <= 2'd0;
            case (in_tuser)
              nrbp_pkg::OP_SPAWN: begin
                if (count_r == nrbp_pkg::CNT_W'(nrbp_pkg::CAPACITY)) begin
                  evict_r <= 1'b1;
                  ptr_r   <= '0;
                  state_r <= S_SHIFT_CHK;
                end else begin
                  evict_r <= 1'b0;
                  state_r <= S_SPAWN_WR;
                end
              end
              nrbp_pkg::OP_REMOVE: begin
                if ({1'b0, in_tdata[226:223]} < (nrbp_pkg::CNT_W + 1)'(count_r)) begin
                  ptr_r   <= nrbp_pkg::CNT_W'(in_tdata[226:223]);
                  state_r <= S_SHIFT_CHK;
                end
              end
              nrbp_pkg::OP_PICK: state_r <= S_SQ;
              default: ;
            endcase
          end
        end
        S_SHIFT_CHK: begin
          if (ptr_inc < {1'b0, count_r}) begin
            state_r <= S_SHIFT_WR;
          end else begin
            count_r <= count_r - 1'b1;
            state_r <= (op_r == nrbp_pkg::OP_SPAWN) ? S_SPAWN_WR : S_IDLE;
          end
        end
        S_SHIFT_WR: begin
          ptr_r   <= ptr_inc[nrbp_pkg::CNT_W-1:0];
          state_r <= S_SHIFT_CHK;
        end
        S_SPAWN_WR: begin
          count_r    <= count_r + 1'b1;
          res_slot_r <= 4'(count_r);
          res_ev_r   <= evict_r;
          res_hit_r  <= 1'b0;
          state_r    <= S_DONE;
        end
        S_SQ: begin
          prod_r   <= sq_op * sq_op;
          acc_r    <= (sq_cnt_r == 2'd0) ? 64'd0 : acc_r + prod_r;
          sq_cnt_r <= sq_cnt_r + 1'b1;
          if (sq_cnt_r == 2'd3) begin
            sres_r  <= '0;
            sbit_r  <= 64'd1 << 62;
            state_r <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (sbit_r == '0) begin
            len_r <= sres_r[nrbp_pkg::DEN_W-1:0];
            if (sres_r == '0) begin
              res_slot_r <= '0;
              res_ev_r   <= 1'b0;
              res_hit_r  <= 1'b0;
              state_r    <= S_DONE;
            end else begin
              axis_r  <= 2'd0;
              state_r <= S_UNIT;
            end
          end else begin
            if (acc_r >= ssum) begin
              acc_r  <= acc_r - ssum;
              sres_r <= (sres_r >> 1) + sbit_r;
            end else begin
              sres_r <= sres_r >> 1;
            end
            sbit_r <= sbit_r >> 2;
          end
        end
        S_UNIT: begin
          div_num_r <= {2'b00, abs32(d_axis), 16'd0};
          div_den_r <= len_r;
          div_neg_r <= d_axis[CW-1];
          div_rem_r <= '0;
          div_cnt_r <= '0;
          unit_ph_r <= 1'b1;
          state_r   <= S_DIV;
        end
        S_DIV: begin
          div_rem_r <= rem_ge ? rem_sub[nrbp_pkg::DEN_W-1:0] : rem_sh[nrbp_pkg::DEN_W-1:0];
          div_num_r <= {div_num_r[nrbp_pkg::DIV_W-2:0], rem_ge};
          div_cnt_r <= div_cnt_r + 1'b1;
          if (div_cnt_r == nrbp_pkg::DCNT_W'(nrbp_pkg::DIV_W - 1)) begin
            state_r <= S_DIV_END;
          end
        end
        S_DIV_END: begin
          if (unit_ph_r) begin
            case (axis_r)
              2'd0:    ux_r <= qs[nrbp_pkg::U_W-1:0];
              2'd1:    uy_r <= qs[nrbp_pkg::U_W-1:0];
              default: uz_r <= qs[nrbp_pkg::U_W-1:0];
            endcase
            if (axis_r == 2'd2) begin
              ptr_r    <= '0;
              found_r  <= 1'b0;
              best_r   <= '0;
              best_t_r <= '0;
              state_r  <= S_BOX_RD;
            end else begin
              axis_r  <= axis_r + 1'b1;
              state_r <= S_UNIT;
            end
          end else if (!bsel_r) begin
            t1_r    <= qs;
            bsel_r  <= 1'b1;
            state_r <= S_SLAB;
          end else begin
            bsel_r <= 1'b0;
            tmin_r <= new_tmin;
            tmax_r <= new_tmax;
            if (new_tmin > new_tmax) begin
              ptr_r   <= ptr_inc[nrbp_pkg::CNT_W-1:0];
              state_r <= S_BOX_RD;
            end else if (axis_r == 2'd2) begin
              if (better_div) begin
                found_r  <= 1'b1;
                best_r   <= ptr_r[nrbp_pkg::IDX_W-1:0];
                best_t_r <= new_tmin;
              end
              ptr_r   <= ptr_inc[nrbp_pkg::CNT_W-1:0];
              state_r <= S_BOX_RD;
            end else begin
              axis_r  <= axis_r + 1'b1;
              state_r <= S_SLAB;
            end
          end
        end
        S_BOX_RD: begin
          if (ptr_r < count_r) begin
            state_r <= S_BOX_LD;
          end else begin
            res_slot_r <= 4'(best_r);
            res_ev_r   <= 1'b0;
            res_hit_r  <= found_r;
            state_r    <= S_DONE;
          end
        end
        S_BOX_LD: begin
          ax_r    <= rd_data_r[CW-1:0];
          ay_r    <= rd_data_r[2*CW-1:CW];
          az_r    <= rd_data_r[3*CW-1:2*CW];
          tmin_r  <= '0;
          tmax_r  <= $signed({20'd0, reach_r});
          axis_r  <= 2'd0;
          bsel_r  <= 1'b0;
          state_r <= S_SLAB;
        end
        S_SLAB: begin
          if (u_sel == '0) begin
            if (outside) begin
              ptr_r   <= ptr_inc[nrbp_pkg::CNT_W-1:0];
              state_r <= S_BOX_RD;
            end else if (axis_r == 2'd2) begin
              if (better_zero) begin
                found_r  <= 1'b1;
                best_r   <= ptr_r[nrbp_pkg::IDX_W-1:0];
                best_t_r <= tmin_r;
              end
              ptr_r   <= ptr_inc[nrbp_pkg::CNT_W-1:0];
              state_r <= S_BOX_RD;
            end else begin
              axis_r <= axis_r + 1'b1;
            end
          end else begin
            div_num_r <= {mag, 16'd0};
            div_den_r <= {15'd0, u_abs};
            div_neg_r <= diff[nrbp_pkg::BND_W-1] ^ u_sel[nrbp_pkg::U_W-1];
            div_rem_r <= '0;
            div_cnt_r <= '0;
            unit_ph_r <= 1'b0;
            state_r   <= S_DIV;
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_tready) begin
            out_slot_r  <= res_slot_r;
            out_ev_r    <= res_ev_r;
            out_hit_r   <= res_hit_r;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= nrbp_pkg::CNT_W'(nrbp_pkg::CAPACITY))
    else $error("entry count above capacity");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result loaded outside the done state");

  a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (div_cnt_r < nrbp_pkg::DCNT_W'(nrbp_pkg::DIV_W)))
    else $error("divider ran past its last step");

  a_pick_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_BOX_RD && ptr_r >= count_r) |=> (state_r == S_DONE && !res_ev_r))
    else $error("pick result carries an eviction");

endmodule
`default_nettype wire

@@ test/nearest_ray_box_picker_tb.sv @@
// Self-checking testbench for nearest_ray_box_picker: spawn, remove, pick and unused-opcode requests.
// A scoreboard class predicts every result from its own copy of the table and box size.
// Depends on nrbp_pkg and the nearest_ray_box_picker RTL.
`timescale 1ns / 1ps
module nearest_ray_box_picker_tb;

  localparam int IDLE_LIMIT = 100000;
  localparam int HOLD_CYCLES = 3000;
  localparam int SETTLE_CYCLES = 100;
  localparam logic [1:0] OP_RESERVED = 2'd3;

  typedef struct {
    logic [3:0] slot;
    logic       evicted;
    logic       hit;
  } pick_result_t;

  class pick_scoreboard;
    longint unsigned box_w, box_l, box_h;
    longint anc_x[nrbp_pkg::CAPACITY];
    longint anc_y[nrbp_pkg::CAPACITY];
    longint anc_z[nrbp_pkg::CAPACITY];
    int count;
    int errors;
    pick_result_t expected_q[$];
    longint tmin, tmax;

    function new();
      box_w = 65536;
      box_l = 65536;
      box_h = 32768;
      count = 0;
      errors = 0;
    endfunction

    function void report(string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      errors++;
    endfunction

    function void set_box(nrbp_pkg::cfg_idx_t idx, logic [nrbp_pkg::CFG_W-1:0] val);
      case (idx)
        nrbp_pkg::CFG_BOX_WIDTH: box_w = val;
        nrbp_pkg::CFG_BOX_LENGTH: box_l = val;
        nrbp_pkg::CFG_BOX_HEIGHT: box_h = val;
        default: ;
      endcase
    endfunction

    function longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res, b;
      res = 0;
      b = 64'h4000_0000_0000_0000;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= res + b) begin
          v = v - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
      return res;
    endfunction

    function void drop_entry(int idx);
      for (int i = idx; i + 1 < count; i++) begin
        anc_x[i] = anc_x[i + 1];
        anc_y[i] = anc_y[i + 1];
        anc_z[i] = anc_z[i + 1];
      end
      count--;
    endfunction

    function bit slab(longint o, longint u, longint lo, longint hi);
      longint t1, t2, tt;
      if (u == 0) return !(o < lo || o > hi);
      t1 = (lo - o) * 65536 / u;
      t2 = (hi - o) * 65536 / u;
      if (t1 > t2) begin
        tt = t1;
        t1 = t2;
        t2 = tt;
      end
      if (t1 > tmin) tmin = t1;
      if (t2 < tmax) tmax = t2;
      return tmin <= tmax;
    endfunction

    function void note_request(logic [1:0] op, logic [nrbp_pkg::IN_TDATA_W-1:0] d);
      pick_result_t r;
      longint px, py, pz, dx, dy, dz, reach, ux, uy, uz, len, hw, hl, best_t;
      longint unsigned sq, adx, ady, adz;
      bit found;
      px = longint'($signed(d[31:0]));
      py = longint'($signed(d[63:32]));
      pz = longint'($signed(d[95:64]));
      dx = longint'($signed(d[127:96]));
      dy = longint'($signed(d[159:128]));
      dz = longint'($signed(d[191:160]));
      reach = longint'(d[222:192]);
      r.slot = 0;
      r.evicted = 0;
      r.hit = 0;
      if (op == nrbp_pkg::OP_SPAWN) begin
        if (count >= nrbp_pkg::CAPACITY) begin
          drop_entry(0);
          r.evicted = 1;
        end
        anc_x[count] = px;
        anc_y[count] = py;
        anc_z[count] = pz;
        count++;
        r.slot = 4'(count - 1);
        expected_q.insert(expected_q.size(), r);
      end else if (op == nrbp_pkg::OP_REMOVE) begin
        if (int'(d[226:223]) < count) drop_entry(int'(d[226:223]));
      end else if (op == nrbp_pkg::OP_PICK) begin
        adx = (dx < 0) ? -dx : dx;
        ady = (dy < 0) ? -dy : dy;
        adz = (dz < 0) ? -dz : dz;
        sq = adx * adx + ady * ady + adz * adz;
        len = longint'(int_sqrt(sq));
        if (len != 0) begin
          ux = dx * 65536 / len;
          uy = dy * 65536 / len;
          uz = dz * 65536 / len;
          hw = longint'(box_w >> 1);
          hl = longint'(box_l >> 1);
          found = 0;
          best_t = 0;
          for (int i = 0; i < count; i++) begin
            tmin = 0;
            tmax = reach;
            if (!slab(px, ux, anc_x[i] - hw, anc_x[i] + hw)) continue;
            if (!slab(py, uy, anc_y[i], anc_y[i] + longint'(box_h))) continue;
            if (!slab(pz, uz, anc_z[i] - hl, anc_z[i] + hl)) continue;
            if (!found || tmin < best_t) begin
              found = 1;
              best_t = tmin;
              r.slot = 4'(i);
              r.hit = 1;
            end
          end
        end
        expected_q.insert(expected_q.size(), r);
      end
    endfunction

    function void check_result(logic [nrbp_pkg::OUT_TDATA_W-1:0] d);
      pick_result_t e;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result %h", d));
        return;
      end
      e = expected_q.pop_front();
      if (d[3:0] !== e.slot) report($sformatf("slot %0d, expected %0d", d[3:0], e.slot));
      if (d[4] !== e.evicted) report($sformatf("evicted %b, expected %b", d[4], e.evicted));
      if (d[5] !== e.hit) report($sformatf("hit %b, expected %b", d[5], e.hit));
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [nrbp_pkg::IN_TDATA_W-1:0] in_tdata = '0;
  logic [1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [nrbp_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic cfg_we = 0;
  logic [1:0] cfg_index = '0;
  logic [nrbp_pkg::CFG_W-1:0] cfg_data = '0;

  pick_scoreboard sb = new();
  bit hold_req = 0;
  int idle_cycles = 0;
  int burst_left = 0;

  nearest_ray_box_picker u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) begin
    if (in_tvalid && in_tready) sb.note_request(in_tuser, in_tdata);
    if (out_tvalid && out_tready) sb.check_result(out_tdata);
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // The receiver changes its stall pattern every so often and holds off once on request.
  initial begin
    int mode, mode_left, cyc;
    bit held;
    mode = 0;
    mode_left = 0;
    cyc = 0;
    held = 0;
    forever begin
      @(negedge clk);
      cyc++;
      if (hold_req && !held) begin
        held = 1;
        out_tready = 0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      if (mode_left == 0) begin
        mode = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 300);
      end
      mode_left--;
      case (mode)
        0: out_tready = 1;
        1: out_tready = $urandom_range(0, 1);
        2: out_tready = ($urandom_range(0, 7) == 0);
        default: out_tready = (cyc % 4 != 0);
      endcase
    end
  end

  function automatic logic [nrbp_pkg::IN_TDATA_W-1:0] pack_req(
      logic [31:0] px, logic [31:0] py, logic [31:0] pz,
      logic [31:0] dx, logic [31:0] dy, logic [31:0] dz,
      logic [30:0] reach, logic [3:0] slot_index);
    return {5'b0, slot_index, reach, dz, dy, dx, pz, py, px};
  endfunction

  task automatic send_req(logic [1:0] op, logic [nrbp_pkg::IN_TDATA_W-1:0] d);
    @(negedge clk);
    in_tvalid = 1;
    in_tuser = op;
    in_tdata = d;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic send_paced(logic [1:0] op, logic [nrbp_pkg::IN_TDATA_W-1:0] d);
    send_req(op, d);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      @(negedge clk);
      in_tvalid = 0;
      repeat ($urandom_range(0, 12)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 15);
    end
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_tvalid = 0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_box(nrbp_pkg::cfg_idx_t idx, logic [nrbp_pkg::CFG_W-1:0] val);
    @(negedge clk);
    cfg_we = 1;
    cfg_index = idx;
    cfg_data = val;
    sb.set_box(idx, val);
    @(negedge clk);
    cfg_we = 0;
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 7))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
      default: return 32'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
    endcase
  endfunction

  function automatic logic [30:0] rand_reach();
    case ($urandom_range(0, 7))
      0: return 31'($urandom);
      1: return $urandom_range(0, 1) ? 31'h7fff_ffff : 31'd0;
      2: return 31'($urandom_range(0, 65536));
      default: return 31'($urandom_range(1 << 20, 1 << 26));
    endcase
  endfunction

  task automatic send_random();
    logic [1:0] op;
    logic [31:0] px, py, pz, dx, dy, dz;
    longint ex, ey, ez;
    int i, sel;
    sel = $urandom_range(0, 99);
    px = rand_coord();
    py = rand_coord();
    pz = rand_coord();
    dx = rand_coord();
    dy = rand_coord();
    dz = rand_coord();
    if (sel < 35) begin
      op = nrbp_pkg::OP_SPAWN;
    end else if (sel < 50) begin
      op = nrbp_pkg::OP_REMOVE;
    end else if (sel < 95) begin
      op = nrbp_pkg::OP_PICK;
      if (sb.count > 0 && $urandom_range(0, 2) != 0) begin
        i = $urandom_range(0, sb.count - 1);
        ex = sb.anc_x[i] - longint'($signed(px)) + $urandom_range(0, 4096) - 2048;
        ey = sb.anc_y[i] + longint'(sb.box_h >> 1) - longint'($signed(py));
        ez = sb.anc_z[i] - longint'($signed(pz)) + $urandom_range(0, 4096) - 2048;
        while (ex > 32'sh7fff_ffff || ex < -32'sh7fff_ffff || ey > 32'sh7fff_ffff ||
               ey < -32'sh7fff_ffff || ez > 32'sh7fff_ffff || ez < -32'sh7fff_ffff) begin
          ex = ex >>> 1;
          ey = ey >>> 1;
          ez = ez >>> 1;
        end
        dx = 32'(ex);
        dy = 32'(ey);
        dz = 32'(ez);
      end else if ($urandom_range(0, 9) == 0) begin
        dx = 0;
        dy = 0;
        dz = $urandom_range(0, 1);
      end
    end else begin
      op = OP_RESERVED;
    end
    send_paced(op, pack_req(px, py, pz, dx, dy, dz, rand_reach(), 4'($urandom_range(0, 15))));
  endtask

  initial begin
    logic [nrbp_pkg::CFG_W-1:0] phase_box[4][3];
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // Directed part with the default box size.
    send_req(nrbp_pkg::OP_PICK, pack_req(0, 0, 0, 32'h1_0000, 0, 0, 31'h7fff_ffff, 0));
    send_req(nrbp_pkg::OP_REMOVE, pack_req(0, 0, 0, 0, 0, 0, 0, 4'd0));
    send_req(OP_RESERVED, pack_req('1, '1, '1, '1, '1, '1, '1, '1));
    send_req(nrbp_pkg::OP_SPAWN,
             pack_req(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0, 0, 0, 0));
    for (int k = 1; k < 16; k++)
      send_req(nrbp_pkg::OP_SPAWN, pack_req(32'(k * 32'h2_0000), 0, 0, 0, 0, 0, 0, 0));
    send_req(nrbp_pkg::OP_SPAWN,
             pack_req(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 0, 0, 0, 0, 0));
    send_req(nrbp_pkg::OP_PICK,
             pack_req(32'hfffc_0000, 32'h4000, 0, 32'h1_0000, 0, 0, 31'h7fff_ffff, 0));
    send_req(nrbp_pkg::OP_PICK,
             pack_req(32'h10_0000, 32'h4000, 0, 32'h8000_0000, 0, 0, 31'h7fff_ffff, 0));
    send_req(nrbp_pkg::OP_PICK, pack_req(0, 0, 0, 0, 0, 0, 31'h7fff_ffff, 0));
    send_req(nrbp_pkg::OP_PICK,
             pack_req(0, 0, 0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0));
    send_req(nrbp_pkg::OP_REMOVE, pack_req(0, 0, 0, 0, 0, 0, 0, 4'd15));
    send_req(nrbp_pkg::OP_REMOVE, pack_req(0, 0, 0, 0, 0, 0, 0, 4'd3));
    send_req(nrbp_pkg::OP_PICK,
             pack_req(32'hfffc_0000, 32'h4000, 0, 32'h7fff_ffff, 1, 0, 31'h7fff_ffff, 0));
    wait_idle();

    phase_box[0] = '{31'($urandom_range(1, 1 << 18)), 31'($urandom_range(1, 1 << 18)),
                     31'($urandom_range(1, 1 << 18))};
    phase_box[1] = '{31'd0, 31'd0, 31'd0};
    phase_box[2] = '{31'h7fff_ffff, 31'h7fff_ffff, 31'h7fff_ffff};
    phase_box[3] = '{31'($urandom), 31'($urandom), 31'($urandom)};
    for (int p = 0; p < 4; p++) begin
      write_box(nrbp_pkg::CFG_BOX_WIDTH, phase_box[p][0]);
      write_box(nrbp_pkg::CFG_BOX_LENGTH, phase_box[p][1]);
      write_box(nrbp_pkg::CFG_BOX_HEIGHT, phase_box[p][2]);
      for (int n = 0; n < 120; n++) begin
        if (p == 0 && n == 30) hold_req = 1;
        send_random();
      end
      wait_idle();
    end

    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
